// ----- src/tli_pkg.sv -----
// Shared types and constants for the breakpoint table interpolator.
// Holds the sequencer and divider state types, table entry and divider
// request/response structs. No dependencies.
package tli_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;
    localparam int INDEX_W = 7;
    localparam int PADDR_W = 3;
    localparam int STEP_W  = 5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic MODE_LINEAR  = 1'b0;
    localparam logic MODE_NEAREST = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_INTERP_MODE = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd2;
    localparam logic [STEP_W-1:0]  LAST_STEP   = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_FIRST,
        ST_CHK_LAST,
        ST_SEARCH,
        ST_COMPUTE,
        ST_WAIT_DIV,
        ST_RESULT
    } tli_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_STEP
    } div_state_t;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] mcand;
        logic [DATA_W-1:0] mplier;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- src/tli_mem.sv -----
// Breakpoint table storage: one write port, one registered read port.
// Depends on tli_pkg for the entry type.
module tli_mem #(
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  tli_pkg::entry_t  wr_data,
    input  logic [AW-1:0]    rd_addr,
    output tli_pkg::entry_t  rd_data
);
    import tli_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/tli_div.sv -----
// Multiply-then-divide unit: floor(mcand * mplier / divisor), unsigned.
// A 32x32 multiply, then 32 restoring steps on a shared subtractor.
// Depends on tli_pkg for the request/response structs and state type.
module tli_div (
    input  logic                clk,
    input  logic                rst_n,
    input  tli_pkg::div_req_t   req,
    output tli_pkg::div_rsp_t   rsp
);
    import tli_pkg::*;

    div_state_t        state_reg, state_next;
    logic [DATA_W-1:0] mcand_reg, mcand_next;
    logic [DATA_W-1:0] mplier_reg, mplier_next;
    logic [DATA_W-1:0] divisor_reg, divisor_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0] count_reg, count_next;
    logic              done_reg, done_next;

    logic [2*DATA_W-1:0] product;
    logic [DATA_W:0]     trial;
    logic [DATA_W+1:0]   diff;

    assign product = mcand_reg * mplier_reg;
    assign trial   = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = {1'b0, trial} - {2'b00, divisor_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    state_next = DIV_MUL;
                end
            end
            DIV_MUL:
            begin
                state_next = DIV_STEP;
            end
            DIV_STEP:
            begin
                if (count_reg == LAST_STEP)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    mcand_next   = req.mcand;
                    mplier_next  = req.mplier;
                    divisor_next = req.divisor;
                end
            end
            DIV_MUL:
            begin
                rem_next   = product[2*DATA_W-1:DATA_W];
                quo_next   = product[DATA_W-1:0];
                count_next = '0;
            end
            DIV_STEP:
            begin
                if (!diff[DATA_W+1])
                begin
                    rem_next = diff[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                count_next = count_reg + 1'b1;
                done_next  = (count_reg == LAST_STEP);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- src/table_interpolator_linear_nearest_top.sv -----
// Piecewise linear / nearest-entry breakpoint table interpolator, top level.
// Holds the query sequencer, config registers and output register.
// Depends on tli_pkg, tli_mem and tli_div.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item: operation
//   0 writes entry entry_index with (x_value, y_value), operation 1 queries
//   x_value. Output channel (out_valid/out_ready) returns one y_result beat
//   per query; writes return nothing. Registers entry_count (addr 0) and
//   interp_mode (addr 4) are written through the APB port, by the user only
//   while idle; the block itself does not enforce this. A write beat leaves
//   the sequencer idle. A query reads the table through one memory read
//   port, one entry per cycle. A query at or below the first x finishes after
//   the first entry is checked, one at or above the last x after the last
//   entry is checked. Otherwise the search runs to the bracketing entry, and
//   linear mode then adds one multiply, 32 restoring divide steps and the
//   handoff of the divider's done flag.
//   in_ready is high only while the sequencer is idle.
//   A finished result waits in the output register while the next beat is
//   taken; a query that finishes while that register is still full holds
//   until the receiver takes the earlier result.
//   Reset clears control state and the registers to entry_count 2 and
//   interp_mode 0; table contents are undefined until written.
module table_interpolator_linear_nearest_top #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tli_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [tli_pkg::INDEX_W-1:0]         entry_index,
    input  logic signed [tli_pkg::DATA_W-1:0]   x_value,
    input  logic signed [tli_pkg::DATA_W-1:0]   y_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tli_pkg::DATA_W-1:0]   y_result
);
    import tli_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    tli_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg;
    logic               mode_reg;
    logic [DATA_W-1:0]  qx_reg, qx_next;
    logic               qmode_reg, qmode_next;
    logic [AW-1:0]      last_reg, last_next;
    logic [AW-1:0]      idx_reg, idx_next;
    entry_t             lo_reg, lo_next;
    entry_t             hi_reg, hi_next;
    logic [DATA_W-1:0]  res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  y_result_reg, y_result_next;

    logic               cfg_wr;
    logic               in_fire;
    logic               query_fire;
    logic               wr_en;
    logic [AW-1:0]      rd_addr;
    entry_t             rd_data;
    entry_t             wr_data;
    logic [AW-1:0]      last_calc;

    logic               first_le;
    logic               last_ge;
    logic               advance;
    logic               slot_free;

    logic [DATA_W:0]    dx_full;
    logic [DATA_W:0]    d_full;
    logic [DATA_W:0]    dy_full;
    logic [DATA_W:0]    dy_neg;
    logic               near_lo;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            mode_reg  <= MODE_LINEAR;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ENTRY_COUNT: count_reg <= pwdata[COUNT_W-1:0];
                REG_INTERP_MODE: mode_reg  <= pwdata[0];
                default:         mode_reg  <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ENTRY_COUNT: prdata = {{(32-COUNT_W){1'b0}}, count_reg};
            REG_INTERP_MODE: prdata = {31'b0, mode_reg};
            default:         prdata = '0;
        endcase
    end

    // Table
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid & in_ready;
    assign query_fire = in_fire & (operation == OP_QUERY);
    assign wr_en      = in_fire & (operation == OP_WRITE)
                        & (int'(entry_index) < TABLE_DEPTH);
    assign wr_data.x  = x_value;
    assign wr_data.y  = y_value;

    tli_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(entry_index)),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        if (count_reg == '0)
        begin
            last_calc = '0;
        end
        else if (int'(count_reg) > TABLE_DEPTH)
        begin
            last_calc = AW'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_calc = AW'(count_reg - 1'b1);
        end
    end

    // Compare and difference terms
    assign first_le  = $signed(qx_reg) <= $signed(rd_data.x);
    assign last_ge   = $signed(qx_reg) >= $signed(rd_data.x);
    assign advance   = (idx_reg < last_reg) && ($signed(rd_data.x) <= $signed(qx_reg));
    assign slot_free = !out_valid_reg || out_ready;

    assign dx_full = {qx_reg[DATA_W-1], qx_reg} - {lo_reg.x[DATA_W-1], lo_reg.x};
    assign d_full  = {hi_reg.x[DATA_W-1], hi_reg.x} - {lo_reg.x[DATA_W-1], lo_reg.x};
    assign dy_full = {hi_reg.y[DATA_W-1], hi_reg.y} - {lo_reg.y[DATA_W-1], lo_reg.y};
    assign dy_neg  = '0 - dy_full;
    assign near_lo = (lo_reg.y == hi_reg.y)
                     || ($signed({dx_full, 1'b0}) < $signed({d_full[DATA_W], d_full}));

    always_comb
    begin
        div_req.start   = (state_reg == ST_COMPUTE) && (qmode_reg == MODE_LINEAR);
        div_req.mcand   = dy_full[DATA_W] ? dy_neg[DATA_W-1:0] : dy_full[DATA_W-1:0];
        div_req.mplier  = dx_full[DATA_W-1:0];
        div_req.divisor = d_full[DATA_W-1:0];
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_fire)
                begin
                    state_next = ST_CHK_FIRST;
                end
            end
            ST_CHK_FIRST:
            begin
                state_next = first_le ? ST_RESULT : ST_CHK_LAST;
            end
            ST_CHK_LAST:
            begin
                state_next = last_ge ? ST_RESULT : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                state_next = advance ? ST_SEARCH : ST_COMPUTE;
            end
            ST_COMPUTE:
            begin
                state_next = (qmode_reg == MODE_NEAREST) ? ST_RESULT : ST_WAIT_DIV;
            end
            ST_WAIT_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and datapath
    always_comb
    begin
        rd_addr        = '0;
        qx_next        = qx_reg;
        qmode_next     = qmode_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_next       = res_reg;
        y_result_next  = y_result_reg;
        out_valid_next = out_valid_reg & !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_fire)
                begin
                    qx_next    = x_value;
                    qmode_next = mode_reg;
                    last_next  = last_calc;
                end
            end
            ST_CHK_FIRST:
            begin
                if (first_le)
                begin
                    res_next = rd_data.y;
                end
                else
                begin
                    lo_next = rd_data;
                    rd_addr = last_reg;
                end
            end
            ST_CHK_LAST:
            begin
                if (last_ge)
                begin
                    res_next = rd_data.y;
                end
                else
                begin
                    rd_addr  = AW'(1);
                    idx_next = AW'(1);
                end
            end
            ST_SEARCH:
            begin
                if (advance)
                begin
                    lo_next  = rd_data;
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
                else
                begin
                    hi_next = rd_data;
                end
            end
            ST_COMPUTE:
            begin
                res_next = near_lo ? lo_reg.y : hi_reg.y;
            end
            ST_WAIT_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next = dy_full[DATA_W] ? lo_reg.y - div_rsp.quotient
                                               : lo_reg.y + div_rsp.quotient;
                end
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    y_result_next  = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg       <= qx_next;
        qmode_reg    <= qmode_next;
        last_reg     <= last_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        res_reg      <= res_next;
        y_result_reg <= y_result_next;
    end

    assign out_valid = out_valid_reg;
    assign y_result  = y_result_reg;

    // Checks
    property p_div_done_in_wait;
        @(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_WAIT_DIV);
    endproperty
    a_div_done_in_wait: assert property (p_div_done_in_wait)
        else $error("divider finished outside the wait state");

    property p_search_in_range;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (idx_reg <= last_reg) && (idx_reg != '0);
    endproperty
    a_search_in_range: assert property (p_search_in_range)
        else $error("search index outside the entries in use");

    property p_write_one_cycle;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation == OP_WRITE)) |=> in_ready;
    endproperty
    a_write_one_cycle: assert property (p_write_one_cycle)
        else $error("write beat did not return to idle");

    property p_result_from_seq;
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT);
    endproperty
    a_result_from_seq: assert property (p_result_from_seq)
        else $error("result beat raised without a finished query");

endmodule

// ----- test/tb_table_interpolator_linear_nearest_top.sv -----
`timescale 1ns / 1ps
// Testbench for table_interpolator_linear_nearest_top: directed table, then random table setups.
// Drives the beat and APB ports and predicts each queried y_result.
// Depends on tli_pkg and the RTL under src/.
module tb_table_interpolator_linear_nearest_top;

    import tli_pkg::*;

    localparam int DEPTH         = 128;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_BEATS  = 1000;
    localparam int MAX_REPORTS   = 10;
    localparam longint unsigned SAT_Q = 64'd1 << 40;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_QUERY,
        ROW_SET_COUNT,
        ROW_SET_MODE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [6:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic        checked;
        logic [31:0] want;
    } step_row_t;

    localparam int NUM_ROWS = 24;
    localparam step_row_t DIRECTED [NUM_ROWS] = '{
        '{ROW_WRITE,     7'h00, 32'hFFFF_0000, 32'h0001_0000, 1'b0, 32'h0},
        '{ROW_WRITE,     7'h01, 32'h0001_0000, 32'h0003_0000, 1'b0, 32'h0},
        '{ROW_QUERY,     7'h00, 32'h8000_0000, 32'h0,         1'b1, 32'h0001_0000},
        '{ROW_QUERY,     7'h00, 32'h7FFF_FFFF, 32'h0,         1'b1, 32'h0003_0000},
        '{ROW_QUERY,     7'h00, 32'hFFFF_0000, 32'h0,         1'b1, 32'h0001_0000},
        '{ROW_QUERY,     7'h00, 32'h0001_0000, 32'h0,         1'b1, 32'h0003_0000},
        '{ROW_QUERY,     7'h00, 32'h0000_0001, 32'h0,         1'b0, 32'h0},
        '{ROW_SET_MODE,  7'h00, {31'd0, MODE_NEAREST}, 32'h0, 1'b0, 32'h0},
        '{ROW_QUERY,     7'h7F, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0003_0000},
        '{ROW_QUERY,     7'h00, 32'hFFFF_FFFF, 32'h0,         1'b1, 32'h0001_0000},
        '{ROW_SET_MODE,  7'h00, {31'd0, MODE_LINEAR}, 32'h0,  1'b0, 32'h0},
        '{ROW_WRITE,     7'h00, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0},
        '{ROW_WRITE,     7'h01, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ROW_QUERY,     7'h00, 32'h0000_0000, 32'h0,         1'b0, 32'h0},
        '{ROW_QUERY,     7'h00, 32'h4000_0000, 32'h0,         1'b0, 32'h0},
        '{ROW_SET_COUNT, 7'h00, 32'd3,         32'h0,         1'b0, 32'h0},
        '{ROW_WRITE,     7'h02, 32'h0001_0000, 32'hFFFB_0000, 1'b0, 32'h0},
        '{ROW_QUERY,     7'h00, 32'h0000_8000, 32'h0,         1'b0, 32'h0},
        '{ROW_QUERY,     7'h00, 32'h0002_0000, 32'h0,         1'b1, 32'hFFFB_0000},
        '{ROW_WRITE,     7'h7F, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0},
        '{ROW_SET_COUNT, 7'h00, 32'd0,         32'h0,         1'b0, 32'h0},
        '{ROW_QUERY,     7'h00, 32'h7FFF_FFFF, 32'h0,         1'b1, 32'h8000_0000},
        '{ROW_QUERY,     7'h00, 32'h8000_0000, 32'h0,         1'b1, 32'h8000_0000},
        '{ROW_SET_MODE,  7'h00, {31'd0, MODE_NEAREST}, 32'h0, 1'b0, 32'h0}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_ready;
    logic                      operation;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [DATA_W-1:0]  x_value;
    logic signed [DATA_W-1:0]  y_value;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [DATA_W-1:0]  y_result;

    logic signed [DATA_W-1:0]  bp_x [DEPTH];
    logic signed [DATA_W-1:0]  bp_y [DEPTH];
    logic [COUNT_W-1:0]        cfg_count;
    logic                      cfg_mode;
    logic signed [DATA_W-1:0]  pending_y [$];

    int  beats_sent;
    int  writes_sent;
    int  queries_checked;
    int  table_setups;
    int  error_count;
    int  cycle_count;
    logic calm;

    assign calm = (beats_sent >= 350) && (beats_sent < 550);

    table_interpolator_linear_nearest_top dut (
        .clk,
        .rst_n,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready,
        .in_valid,
        .in_ready,
        .operation,
        .entry_index,
        .x_value,
        .y_value,
        .out_valid,
        .out_ready,
        .y_result
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic signed [31:0] lerp_q16(input longint qx, input longint x1,
                                                    input longint y1, input longint x2,
                                                    input longint y2);
        longint span, dx, dy, r;
        longint unsigned span_m, dx_m, dy_m, whole, rem, q;
        logic neg;
        span = x2 - x1;
        dx   = qx - x1;
        dy   = y2 - y1;
        if (span == 0)
            return 32'(y1);
        span_m = (span < 0) ? -span : span;
        dx_m   = (dx < 0) ? -dx : dx;
        dy_m   = (dy < 0) ? -dy : dy;
        neg    = ((span < 0) != (dx < 0)) != (dy < 0);
        if (dx == 0 || dy == 0)
            return 32'(y1);
        whole = dy_m / span_m;
        rem   = dy_m % span_m;
        if (whole != 0 && dx_m > SAT_Q / whole)
            q = SAT_Q;
        else
            q = whole * dx_m + (rem * dx_m) / span_m;
        if (q > SAT_Q)
            q = SAT_Q;
        r = neg ? y1 - longint'(q) : y1 + longint'(q);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return 32'(r);
    endfunction

    function automatic logic signed [31:0] lookup_y(input logic signed [31:0] qx);
        int unsigned used, last, i;
        longint x1, x2;
        used = cfg_count;
        if (used < 1)
            used = 1;
        if (used > DEPTH)
            used = DEPTH;
        last = used - 1;
        if (qx <= bp_x[0])
            return bp_y[0];
        if (qx >= bp_x[last])
            return bp_y[last];
        i = 1;
        while (i < last && bp_x[i] <= qx)
            i++;
        if (cfg_mode == MODE_LINEAR)
            return lerp_q16(qx, bp_x[i-1], bp_y[i-1], bp_x[i], bp_y[i]);
        x1 = bp_x[i-1];
        x2 = bp_x[i];
        if (bp_y[i-1] == bp_y[i] || 2 * (longint'(qx) - x1) < x2 - x1)
            return bp_y[i-1];
        return bp_y[i];
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endtask

    task automatic send_beat(input logic op, input logic [6:0] idx,
                             input logic signed [31:0] xv, input logic signed [31:0] yv,
                             input logic checked, input logic signed [31:0] want);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 15)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        entry_index <= idx;
        x_value     <= xv;
        y_value     <= yv;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
        if (op == OP_WRITE)
        begin
            bp_x[idx] = xv;
            bp_y[idx] = yv;
            writes_sent++;
        end
        else
        begin
            pending_y.push_back(checked ? want : lookup_y(xv));
            queries_checked++;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_y.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_ENTRY_COUNT)
            cfg_count = value[COUNT_W-1:0];
        else
            cfg_mode = value[0];
    endtask

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 15);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_y.size() == 0)
                report_error($sformatf("y_result %h with no query waiting", y_result));
            else
            begin
                if (y_result !== pending_y[0])
                    report_error($sformatf("y_result mismatch: expected %h, got %h",
                                           pending_y[0], y_result));
                void'(pending_y.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_y.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : main
        int phase, eff, nq, k, sel;
        logic [7:0] cnt;
        logic mode;
        longint lo, span;
        logic signed [31:0] qx;
        int sorted_knots[$];
        int knots[$];
        int order[$];
        int ys[$];

        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        operation   <= OP_WRITE;
        entry_index <= '0;
        x_value     <= '0;
        y_value     <= '0;
        out_ready   <= 1'b0;
        rst_n       <= 1'b0;
        beats_sent      = 0;
        writes_sent     = 0;
        queries_checked = 0;
        table_setups    = 0;
        error_count     = 0;
        cycle_count     = 0;
        cfg_count       = COUNT_RESET;
        cfg_mode        = MODE_LINEAR;
        for (int n = 0; n < DEPTH; n++)
        begin
            bp_x[n] = '0;
            bp_y[n] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            case (DIRECTED[r].kind)
                ROW_WRITE:
                    send_beat(OP_WRITE, DIRECTED[r].idx, DIRECTED[r].x, DIRECTED[r].y,
                              1'b0, '0);
                ROW_QUERY:
                    send_beat(OP_QUERY, DIRECTED[r].idx, DIRECTED[r].x, DIRECTED[r].y,
                              DIRECTED[r].checked, DIRECTED[r].want);
                ROW_SET_COUNT:
                begin
                    settle();
                    write_reg(REG_ENTRY_COUNT, DIRECTED[r].x);
                end
                default:
                begin
                    settle();
                    write_reg(REG_INTERP_MODE, DIRECTED[r].x);
                end
            endcase
        end

        phase = 0;
        while (beats_sent < NUM_ROWS + RANDOM_BEATS)
        begin
            case (phase)
                0: begin cnt = 8'd128; mode = MODE_LINEAR;  end
                1: begin cnt = 8'd255; mode = MODE_NEAREST; end
                2: begin cnt = 8'd1;   mode = MODE_LINEAR;  end
                3: begin cnt = 8'd2;   mode = MODE_NEAREST; end
                default:
                begin
                    mode = 1'($urandom_range(1));
                    case ($urandom_range(9))
                        0: cnt = 8'($urandom_range(0, 1) ? 0 : $urandom_range(129, 255));
                        1: cnt = 8'($urandom_range(17, 128));
                        default: cnt = 8'($urandom_range(1, 16));
                    endcase
                end
            endcase
            settle();
            write_reg(REG_ENTRY_COUNT, {24'd0, cnt});
            write_reg(REG_INTERP_MODE, {31'd0, mode});
            table_setups++;
            eff = (cnt == 0) ? 1 : (cnt > DEPTH) ? DEPTH : cnt;

            // build the breakpoints: mostly sorted, sometimes out of order
            sorted_knots.delete();
            ys.delete();
            order.delete();
            sel = $urandom_range(0, 24);
            for (k = 0; k < eff; k++)
            begin
                sorted_knots.push_back(int'($urandom) >>> sel);
                ys.push_back(int'($urandom) >>> $urandom_range(0, 20));
                order.push_back(k);
            end
            sorted_knots.sort();
            for (k = 1; k < eff; k++)
                if (sorted_knots[k] <= sorted_knots[k-1] && sorted_knots[k-1] != 32'h7FFF_FFFF)
                    sorted_knots[k] = sorted_knots[k-1] + 1;
            knots = sorted_knots;
            if ($urandom_range(7) == 0)
                knots.shuffle();
            order.shuffle();
            for (k = 0; k < eff; k++)
                send_beat(OP_WRITE, 7'(order[k]), knots[order[k]], ys[order[k]], 1'b0, '0);

            nq = $urandom_range(6, 30);
            for (int n = 0; n < nq; n++)
            begin
                if (eff < DEPTH && $urandom_range(9) == 0)
                    send_beat(OP_WRITE, 7'($urandom_range(eff, DEPTH - 1)), $urandom,
                              $urandom, 1'b0, '0);
                sel = $urandom_range(9);
                if (sel < 6 && eff > 1)
                begin
                    k    = $urandom_range(eff - 2);
                    lo   = sorted_knots[k];
                    span = longint'(sorted_knots[k+1]) - lo;
                    qx   = (span > 0) ? 32'(lo + longint'($urandom) % span) : 32'(lo);
                end
                else if (sel < 8)
                    qx = knots[$urandom_range(eff - 1)];
                else if (sel == 8)
                    qx = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                else
                    qx = $urandom;
                send_beat(OP_QUERY, 7'($urandom), qx, $urandom, 1'b0, '0);
            end
            phase++;
        end

        settle();
        if (pending_y.size() != 0)
            report_error($sformatf("%0d expected results never arrived", pending_y.size()));
        $display("%0d beats (%0d table writes, %0d queries) over %0d table setups",
                 beats_sent, writes_sent, queries_checked, table_setups + 1);
        $display("%0d mismatches, %0d cycles", error_count, cycle_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
src/tli_pkg.sv
src/tli_mem.sv
src/tli_div.sv
src/table_interpolator_linear_nearest_top.sv
test/tb_table_interpolator_linear_nearest_top.sv
